FILE: sv/multilevel_page_free_list_defines.svh
// Assertion macros for the multilevel page free list.
// Taken in by the files that carry concurrent checks; no other dependencies.
`ifndef MULTILEVEL_PAGE_FREE_LIST_DEFINES_SVH
`define MULTILEVEL_PAGE_FREE_LIST_DEFINES_SVH
`ifndef SYNTHESIS
`define MPFL_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("mpfl: assertion failed");
`define MPFL_ASSERT_NEVER(lbl, clk, rst, expr) \
  `MPFL_ASSERT(lbl, clk, rst, !(expr))
`else
`define MPFL_ASSERT(lbl, clk, rst, prop)
`define MPFL_ASSERT_NEVER(lbl, clk, rst, expr)
`endif
`endif

FILE: sv/mpfl_pkg.sv
// Shared types, codes and constants of the multilevel page free list.
// No dependencies; used by the link RAM and the top level.
package mpfl_pkg;

  // default configuration
  localparam int unsigned FANOUT_DEF     = 512;
  localparam int unsigned LEVELS_DEF     = 5;
  localparam int unsigned FRAME_BITS_DEF = 16;

  // command codes
  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK             = 2'd0;
  localparam logic [1:0] ST_UPPER_NONE     = 2'd1;
  localparam logic [1:0] ST_BASE_EXHAUSTED = 2'd2;
  localparam logic [1:0] ST_BAD_LEVEL      = 2'd3;

  typedef struct packed {
    logic        cmd;
    logic [2:0]  level;
    logic [15:0] frame;
  } req_word_t;

  typedef struct packed {
    logic [15:0] page_frame;
    logic [1:0]  status;
  } rsp_word_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_POP,
    S_SPLIT,
    S_FINISH
  } state_t;

  // frame distance between sub-pages at a level: fanout^(lvl-1), elaboration only
  function automatic logic [63:0] step_calc(input int unsigned fanout,
                                            input int unsigned lvl);
    logic [63:0] s;
    s = 64'd1;
    for (int unsigned i = 1; i < lvl; i++) begin
      s = s * 64'(fanout);
    end
    return s;
  endfunction

endpackage

FILE: sv/mpfl_link_ram.sv
// Next-link store of the free lists: one write port, one registered read port.
// Depends on mpfl_pkg for its default widths; no reset, contents undefined until written.
module mpfl_link_ram #(
  parameter int unsigned ADDR_W = mpfl_pkg::FRAME_BITS_DEF,
  parameter int unsigned DATA_W = mpfl_pkg::FRAME_BITS_DEF
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/multilevel_page_free_list.sv
// Multilevel page free list: one LIFO list per level, split-on-demand allocator.
// Return: decode (S_DECIDE), then the result is registered from S_FINISH. Get from a
// non-empty list: decode, unlink of the list head (S_POP), then S_FINISH. A split pushes
// FANOUT-1 sub-pages per level descended, one sub-page push per cycle through the link
// RAM write port. One word in flight; an untaken result holds the next one in its final
// state. Reset (rst, synchronous): all lists empty.
`include "multilevel_page_free_list_defines.svh"

module multilevel_page_free_list #(
  parameter int unsigned FANOUT     = mpfl_pkg::FANOUT_DEF,
  parameter int unsigned LEVELS     = mpfl_pkg::LEVELS_DEF,
  parameter int unsigned FRAME_BITS = mpfl_pkg::FRAME_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  mpfl_pkg::req_word_t req_word,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output mpfl_pkg::rsp_word_t rsp_word
);

  localparam int unsigned IDX_W = $clog2(LEVELS);
  localparam int unsigned CNT_W = $clog2(FANOUT);
  localparam logic [2:0]  LEVEL_TOP = 3'(LEVELS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FANOUT - 2);

  mpfl_pkg::state_t state, state_next;
  mpfl_pkg::req_word_t req_r;

  logic [FRAME_BITS-1:0] heads [LEVELS];
  logic [FRAME_BITS-1:0] step_tab [LEVELS];
  logic [FRAME_BITS-1:0] got;
  logic [1:0]            status_r;
  logic [2:0]            k;
  logic [CNT_W-1:0]      cnt;

  // sub-page distance per level, fixed at elaboration
  for (genvar g = 0; g < LEVELS; g++) begin : g_step
    localparam logic [63:0] STEP_G = mpfl_pkg::step_calc(FANOUT, g + 1);
    assign step_tab[g] = STEP_G[FRAME_BITS-1:0];
  end

  // request decode
  logic [2:0]            lvl_m1, k_m1;
  logic [IDX_W-1:0]      lvl_idx, k_idx, src_idx, hd_idx;
  logic                  lvl_ok, is_put, src_found;
  logic [FRAME_BITS+15:0] frame_wide, got_wide;
  logic [FRAME_BITS-1:0] frame_ext, head_rd, got_step;

  assign lvl_m1     = req_r.level - 3'd1;
  assign k_m1       = k - 3'd1;
  assign lvl_idx    = lvl_m1[IDX_W-1:0];
  assign k_idx      = k_m1[IDX_W-1:0];
  assign lvl_ok     = (req_r.level != 3'd0) && (req_r.level <= LEVEL_TOP);
  assign is_put     = (req_r.cmd == mpfl_pkg::CMD_PUT);
  assign frame_wide = {{FRAME_BITS{1'b0}}, req_r.frame};
  assign frame_ext  = frame_wide[FRAME_BITS-1:0];
  assign got_wide   = {16'd0, got};
  assign got_step   = got + step_tab[k_idx];

  // lowest non-empty level at or above the request
  always_comb begin
    src_found = 1'b0;
    src_idx   = '0;
    for (int g = LEVELS - 1; g >= 0; g--) begin
      if (IDX_W'(g) >= lvl_idx && heads[g] != '0) begin
        src_found = 1'b1;
        src_idx   = IDX_W'(g);
      end
    end
  end

  // single head read/write index
  always_comb begin
    if (state == mpfl_pkg::S_DECIDE) begin
      hd_idx = is_put ? lvl_idx : src_idx;
    end else begin
      hd_idx = k_idx;
    end
  end
  assign head_rd = heads[hd_idx];

  // link RAM
  logic                  ram_we, ram_re;
  logic [FRAME_BITS-1:0] ram_waddr, ram_rdata;

  mpfl_link_ram #(
    .ADDR_W(FRAME_BITS),
    .DATA_W(FRAME_BITS)
  ) u_link_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(head_rd),
    .re   (ram_re),
    .raddr(head_rd),
    .rdata(ram_rdata)
  );

  logic out_free;
  assign out_free  = !rsp_valid || rsp_ready;
  assign req_ready = (state == mpfl_pkg::S_IDLE);

  // sequencer: next state and RAM strobes
  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_waddr  = got;
    unique case (state)
      mpfl_pkg::S_IDLE: begin
        if (req_valid) begin
          state_next = mpfl_pkg::S_DECIDE;
        end
      end
      mpfl_pkg::S_DECIDE: begin
        if (!lvl_ok) begin
          state_next = mpfl_pkg::S_FINISH;
        end else if (is_put) begin
          ram_we     = 1'b1;
          ram_waddr  = frame_ext;
          state_next = mpfl_pkg::S_FINISH;
        end else if (src_found) begin
          ram_re     = 1'b1;
          state_next = mpfl_pkg::S_POP;
        end else begin
          state_next = mpfl_pkg::S_FINISH;
        end
      end
      mpfl_pkg::S_POP: begin
        state_next = (k > req_r.level) ? mpfl_pkg::S_SPLIT : mpfl_pkg::S_FINISH;
      end
      mpfl_pkg::S_SPLIT: begin
        ram_we = 1'b1;
        if (cnt == CNT_LAST && k == req_r.level) begin
          state_next = mpfl_pkg::S_FINISH;
        end
      end
      mpfl_pkg::S_FINISH: begin
        if (out_free) begin
          state_next = mpfl_pkg::S_IDLE;
        end
      end
      default: state_next = mpfl_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mpfl_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath: request hold, working frame, level and sub-page counters
  always_ff @(posedge clk) begin
    case (state)
      mpfl_pkg::S_IDLE: begin
        if (req_valid) begin
          req_r <= req_word;
        end
      end
      mpfl_pkg::S_DECIDE: begin
        if (!lvl_ok) begin
          got      <= '0;
          status_r <= mpfl_pkg::ST_BAD_LEVEL;
        end else if (is_put) begin
          got      <= '0;
          status_r <= mpfl_pkg::ST_OK;
        end else if (src_found) begin
          got      <= head_rd;
          status_r <= mpfl_pkg::ST_OK;
          k        <= 3'(src_idx) + 3'd1;
        end else if (req_r.level == 3'd1) begin
          got      <= '0;
          status_r <= mpfl_pkg::ST_BASE_EXHAUSTED;
        end else begin
          got      <= '0;
          status_r <= mpfl_pkg::ST_UPPER_NONE;
        end
      end
      mpfl_pkg::S_POP: begin
        cnt <= '0;
        if (k > req_r.level) begin
          k <= k_m1;
        end
      end
      mpfl_pkg::S_SPLIT: begin
        got <= got_step;
        if (cnt == CNT_LAST && k != req_r.level) begin
          k   <= k_m1;
          cnt <= '0;
        end else begin
          cnt <= cnt + CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  // list heads: push on return and split, unlink on pop
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int g = 0; g < LEVELS; g++) begin
        heads[g] <= '0;
      end
    end else begin
      case (state)
        mpfl_pkg::S_DECIDE: begin
          if (lvl_ok && is_put) begin
            heads[hd_idx] <= frame_ext;
          end
        end
        mpfl_pkg::S_POP:   heads[k_idx] <= ram_rdata;
        mpfl_pkg::S_SPLIT: heads[k_idx] <= got;
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == mpfl_pkg::S_FINISH && out_free) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == mpfl_pkg::S_FINISH && out_free) begin
      rsp_word.page_frame <= got_wide[15:0];
      rsp_word.status     <= status_r;
    end
  end

  // checks
  `MPFL_ASSERT(a_split_range, clk, rst, (state == mpfl_pkg::S_SPLIT) |-> (k >= req_r.level && k != 3'd0 && cnt <= CNT_LAST))
  `MPFL_ASSERT(a_pop_range, clk, rst, (state == mpfl_pkg::S_POP) |-> (k >= req_r.level && k <= LEVEL_TOP && k != 3'd0))
  `MPFL_ASSERT_NEVER(a_fail_frame, clk, rst, state == mpfl_pkg::S_FINISH && status_r != mpfl_pkg::ST_OK && got != '0)

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for multilevel_page_free_list: a directed table, then random get and
// return words, each response checked against its typed-in expectation or a behavioral model
// of the per-level free lists. Depends on mpfl_pkg and the multilevel_page_free_list RTL.
module testbench;

  localparam int unsigned FANOUT       = mpfl_pkg::FANOUT_DEF;
  localparam int unsigned NUM_LEVELS   = mpfl_pkg::LEVELS_DEF;
  localparam int unsigned RANDOM_WORDS = 1926;
  localparam int unsigned TAIL_CYCLES  = 16;
  localparam bit          KNOWN        = 1'b1;
  localparam bit          PREDICT      = 1'b0;

  typedef struct {
    mpfl_pkg::req_word_t word;
    bit                  known;
    mpfl_pkg::rsp_word_t want;
  } dir_row_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_PERIODIC,
    RX_SLOW
  } rx_mode_t;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                req_valid = 1'b0;
  logic                req_ready;
  mpfl_pkg::req_word_t req_word  = '0;
  logic                rsp_valid;
  logic                rsp_ready = 1'b0;
  mpfl_pkg::rsp_word_t rsp_word;

  // expectation carried along with the word on offer (typed-in rows only)
  bit                  word_known = 1'b0;
  mpfl_pkg::rsp_word_t word_want  = '0;

  // model state: list heads per level and the link store
  bit [15:0]           free_head [1:NUM_LEVELS];
  bit [15:0]           link_mem [0:65535];
  mpfl_pkg::rsp_word_t pending_rsp [$];

  int unsigned errors         = 0;
  int unsigned words_sent     = 0;
  int unsigned grants         = 0;
  int unsigned returns        = 0;
  int unsigned refusals_base  = 0;
  int unsigned refusals_upper = 0;
  int unsigned bad_levels     = 0;
  int unsigned subpages       = 0;
  int unsigned burst_left     = 0;

  rx_mode_t    rx_mode  = RX_OPEN;
  logic [15:0] rx_cycle = '0;

  multilevel_page_free_list u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_word  (req_word),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_word  (rsp_word)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void push_free(input int unsigned lvl, input bit [15:0] fr);
    link_mem[fr]   = free_head[lvl];
    free_head[lvl] = fr;
  endfunction

  // one word through the allocator model; updates lists and returns the response
  function automatic mpfl_pkg::rsp_word_t predict_alloc(input mpfl_pkg::req_word_t w);
    mpfl_pkg::rsp_word_t r;
    int                  lvl;
    int                  src;
    bit [15:0]           got;
    bit [15:0]           stride;
    bit [63:0]           wide;
    r.page_frame = '0;
    r.status     = mpfl_pkg::ST_OK;
    lvl          = w.level;
    if (lvl < 1 || lvl > NUM_LEVELS) begin
      r.status = mpfl_pkg::ST_BAD_LEVEL;
      bad_levels++;
    end else if (w.cmd == mpfl_pkg::CMD_PUT) begin
      push_free(lvl, w.frame);
      returns++;
    end else begin
      // lowest level at or above the request that still has a page
      src = lvl;
      while (src <= NUM_LEVELS && free_head[src] == 16'd0) src++;
      if (src > NUM_LEVELS) begin
        r.status = (lvl == 1) ? mpfl_pkg::ST_BASE_EXHAUSTED : mpfl_pkg::ST_UPPER_NONE;
        if (lvl == 1) refusals_base++;
        else refusals_upper++;
      end else begin
        got            = free_head[src];
        free_head[src] = link_mem[got];
        // split down level by level; all but the last sub-page go on the list
        for (int k = src - 1; k >= lvl; k--) begin
          wide = 64'd1;
          for (int i = 1; i < k; i++) wide = wide * 64'(FANOUT);
          stride = wide[15:0];
          for (int i = 0; i < FANOUT - 1; i++) begin
            push_free(k, got);
            got = got + stride;
            subpages++;
          end
        end
        r.page_frame = got;
        grants++;
      end
    end
    return r;
  endfunction

  // response check, then model update for an accepted request
  always @(posedge clk) begin
    mpfl_pkg::rsp_word_t want;
    mpfl_pkg::rsp_word_t model;
    if (!rst) begin
      if (rsp_valid && rsp_ready) begin
        if (pending_rsp.size() == 0) begin
          errors++;
          $display("%0t: unexpected word: expected none, actual page_frame %h status %0d",
                   $time, rsp_word.page_frame, rsp_word.status);
        end else begin
          want = pending_rsp.pop_front();
          if (rsp_word.page_frame !== want.page_frame || rsp_word.status !== want.status) begin
            errors++;
            $display("%0t: mismatch: expected page_frame %h status %0d, %s %h status %0d",
                     $time, want.page_frame, want.status, "actual page_frame",
                     rsp_word.page_frame, rsp_word.status);
          end
        end
      end
      if (req_valid && req_ready) begin
        model = predict_alloc(req_word);
        pending_rsp.push_back(word_known ? word_want : model);
      end
    end
  end

  // receiver: backpressure pattern redrawn at random whenever rx_cycle[6:0] is zero
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 16'd1;
    if (rx_cycle[6:0] == 7'd0) rx_mode <= rx_mode_t'($urandom_range(0, 3));
    case (rx_mode)
      RX_OPEN:     rsp_ready <= 1'b1;
      RX_COIN:     rsp_ready <= 1'($urandom_range(0, 1));
      RX_PERIODIC: rsp_ready <= (rx_cycle[1:0] != 2'd3);
      default:     rsp_ready <= ($urandom_range(0, 9) == 0) ? ~rsp_ready : rsp_ready;
    endcase
  end

  function automatic mpfl_pkg::req_word_t make_word(input logic cmd, input int unsigned lvl,
                                                    input logic [15:0] frame);
    mpfl_pkg::req_word_t w;
    w.cmd   = cmd;
    w.level = 3'(lvl);
    w.frame = frame;
    return w;
  endfunction

  function automatic dir_row_t row(input logic cmd, input int unsigned lvl,
                                   input logic [15:0] frame, input bit known,
                                   input logic [15:0] pf, input logic [1:0] st);
    dir_row_t d;
    d.word            = make_word(cmd, lvl, frame);
    d.known           = known;
    d.want.page_frame = pf;
    d.want.status     = st;
    return d;
  endfunction

  // offer one word, wait for the handshake, then maybe idle between bursts
  task automatic send_word(input mpfl_pkg::req_word_t w, input bit known,
                           input mpfl_pkg::rsp_word_t want);
    int unsigned gap;
    req_valid  <= 1'b1;
    req_word   <= w;
    word_known <= known;
    word_want  <= want;
    do @(posedge clk); while (!req_ready);
    words_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 12);
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(0, 12);
    end
  endtask

  function automatic mpfl_pkg::req_word_t random_word();
    mpfl_pkg::req_word_t w;
    int unsigned         pick;
    w.cmd = ($urandom_range(0, 99) < 55) ? mpfl_pkg::CMD_GET : mpfl_pkg::CMD_PUT;
    pick  = $urandom_range(0, 99);
    if (pick < 45) w.level = 3'd1;
    else if (pick < 65) w.level = 3'd2;
    else if (pick < 75) w.level = 3'd3;
    else if (pick < 83) w.level = 3'd4;
    else if (pick < 92) w.level = 3'd5;
    else w.level = 3'($urandom_range(0, 7));
    // mostly arbitrary frames, some level-2 aligned, a few zero
    pick = $urandom_range(0, 9);
    if (pick < 7) w.frame = 16'($urandom);
    else if (pick < 9) w.frame = {7'($urandom), 9'd0};
    else w.frame = 16'h0000;
    return w;
  endfunction

  // empty some lower lists by pushing frame 0, feed one top-level page, then split it down
  task automatic deep_split_run();
    mpfl_pkg::rsp_word_t none;
    none = '0;
    for (int lvl = 1; lvl < NUM_LEVELS; lvl++) begin
      if ($urandom_range(0, 3) != 0) begin
        send_word(make_word(mpfl_pkg::CMD_PUT, lvl, 16'h0000), PREDICT, none);
      end
    end
    send_word(make_word(mpfl_pkg::CMD_PUT, NUM_LEVELS, 16'($urandom)), PREDICT, none);
    send_word(make_word(mpfl_pkg::CMD_GET, $urandom_range(1, NUM_LEVELS - 1), 16'($urandom)),
              PREDICT, none);
    repeat ($urandom_range(1, 3)) begin
      send_word(make_word(mpfl_pkg::CMD_GET, 1, 16'($urandom)), PREDICT, none);
    end
  endtask

  initial begin
    dir_row_t            dir_table [$];
    mpfl_pkg::rsp_word_t none;
    none = '0;
    dir_table = '{
      row(mpfl_pkg::CMD_GET, 1, 16'h0000, KNOWN, 16'h0000, mpfl_pkg::ST_BASE_EXHAUSTED),
      row(mpfl_pkg::CMD_GET, 2, 16'hFFFF, KNOWN, 16'h0000, mpfl_pkg::ST_UPPER_NONE),
      row(mpfl_pkg::CMD_GET, 5, 16'h0000, KNOWN, 16'h0000, mpfl_pkg::ST_UPPER_NONE),
      row(mpfl_pkg::CMD_GET, 0, 16'hFFFF, KNOWN, 16'h0000, mpfl_pkg::ST_BAD_LEVEL),
      row(mpfl_pkg::CMD_PUT, 0, 16'hFFFF, KNOWN, 16'h0000, mpfl_pkg::ST_BAD_LEVEL),
      row(mpfl_pkg::CMD_PUT, 6, 16'h1234, KNOWN, 16'h0000, mpfl_pkg::ST_BAD_LEVEL),
      row(mpfl_pkg::CMD_PUT, 7, 16'hFFFF, KNOWN, 16'h0000, mpfl_pkg::ST_BAD_LEVEL),
      row(mpfl_pkg::CMD_GET, 7, 16'h0000, KNOWN, 16'h0000, mpfl_pkg::ST_BAD_LEVEL),
      // frame 0 pushed: the list still reads as empty
      row(mpfl_pkg::CMD_PUT, 1, 16'h0000, KNOWN, 16'h0000, mpfl_pkg::ST_OK),
      row(mpfl_pkg::CMD_GET, 1, 16'h0000, KNOWN, 16'h0000, mpfl_pkg::ST_BASE_EXHAUSTED),
      row(mpfl_pkg::CMD_PUT, 1, 16'hFFFF, KNOWN, 16'h0000, mpfl_pkg::ST_OK),
      row(mpfl_pkg::CMD_GET, 1, 16'h0000, KNOWN, 16'hFFFF, mpfl_pkg::ST_OK),
      // one-level split, then a split from the top down to level 2
      row(mpfl_pkg::CMD_PUT, 2, 16'h0200, KNOWN,   16'h0000, mpfl_pkg::ST_OK),
      row(mpfl_pkg::CMD_GET, 1, 16'h0000, PREDICT, 16'h0000, mpfl_pkg::ST_OK),
      row(mpfl_pkg::CMD_GET, 1, 16'h0000, PREDICT, 16'h0000, mpfl_pkg::ST_OK),
      row(mpfl_pkg::CMD_PUT, 5, 16'h8000, KNOWN,   16'h0000, mpfl_pkg::ST_OK),
      row(mpfl_pkg::CMD_GET, 2, 16'h0000, PREDICT, 16'h0000, mpfl_pkg::ST_OK),
      row(mpfl_pkg::CMD_GET, 4, 16'h0000, PREDICT, 16'h0000, mpfl_pkg::ST_OK),
      row(mpfl_pkg::CMD_GET, 3, 16'h0000, PREDICT, 16'h0000, mpfl_pkg::ST_OK),
      row(mpfl_pkg::CMD_PUT, 5, 16'hFFFF, KNOWN,   16'h0000, mpfl_pkg::ST_OK),
      row(mpfl_pkg::CMD_GET, 5, 16'h0000, KNOWN,   16'hFFFF, mpfl_pkg::ST_OK),
      row(mpfl_pkg::CMD_PUT, 4, 16'h0000, KNOWN,   16'h0000, mpfl_pkg::ST_OK),
      row(mpfl_pkg::CMD_GET, 4, 16'h0000, PREDICT, 16'h0000, mpfl_pkg::ST_OK),
      row(mpfl_pkg::CMD_GET, 1, 16'h0000, PREDICT, 16'h0000, mpfl_pkg::ST_OK)
    };
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_table[i]) send_word(dir_table[i].word, dir_table[i].known, dir_table[i].want);

    while (words_sent < dir_table.size() + RANDOM_WORDS) begin
      if ($urandom_range(0, 99) < 6) deep_split_run();
      else send_word(random_word(), PREDICT, none);
    end
    req_valid <= 1'b0;

    // drain, then a short tail to catch stray words
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d words: %0d pages granted, %0d returned, %0d sub-pages pushed by splits",
             words_sent, grants, returns, subpages);
    $display("refused: %0d base exhausted, %0d none at upper level, %0d invalid level",
             refusals_base, refusals_upper, bad_levels);
    if (errors == 0) begin
      $display("multilevel_page_free_list regression: pass");
    end else begin
      $display("multilevel_page_free_list regression: fail");
    end
    $finish;
  end

  // hang guard, sized for every word taking the deepest split
  initial begin
    #60_000_000;
    $display("multilevel_page_free_list regression: fail");
    $finish;
  end

endmodule
